// ===== rtl/mmad_pkg.sv =====
// mmad_pkg: widths, reset values, register codes and shared types for the
// multichannel moving average with deadband block
// no dependencies
`timescale 1ns / 1ps

package mmad_pkg;

    // field widths
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 16;
    localparam int Q_W      = 20;
    localparam int SUM_W    = 24;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;

    // apb port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // default sizing
    localparam int DEF_WINDOW   = 10;
    localparam int DEF_CHANNELS = 8;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd5701;
    localparam logic [Q_W-1:0]     THRESH_RESET = 20'd410;

    localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

    // rounding constant for the Q12.20 -> Q8.12 conversion
    localparam logic [PROD_W:0] ROUND_HALF = 33'd128;
    localparam int              ROUND_SHIFT = 8;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SCALE  = 1'b0,
        REG_THRESH = 1'b1
    } reg_idx_t;

    // push request into the window/sum store
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] channel;
    } push_req_t;

endpackage

// ===== rtl/mmad_if.sv =====
// mmad_in_if / mmad_out_if: valid/ready stream channels for samples and results
// depends on mmad_pkg
`timescale 1ns / 1ps

interface mmad_in_if;
    logic                             valid;
    logic                             ready;
    logic [mmad_pkg::CH_W-1:0]        channel;
    logic [mmad_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, channel, sample, input ready);
    modport sink (input valid, channel, sample, output ready);
endinterface

interface mmad_out_if;
    logic                         valid;
    logic                         ready;
    logic [mmad_pkg::CH_W-1:0]    out_channel;
    logic [mmad_pkg::Q_W-1:0]     filtered;
    logic [mmad_pkg::Q_W-1:0]     held_value;
    logic                         updated;
    logic                         saturated;

    modport source (output valid, out_channel, filtered, held_value, updated, saturated,
                    input ready);
    modport sink (input valid, out_channel, filtered, held_value, updated, saturated,
                  output ready);
endinterface

// ===== rtl/mmad_window_sum.sv =====
// mmad_window_sum: per-channel shift lines of the last WINDOW scaled samples
// and per-channel running sums; depends on mmad_pkg
`timescale 1ns / 1ps

module mmad_window_sum #(
    parameter int WINDOW   = mmad_pkg::DEF_WINDOW,
    parameter int CHANNELS = mmad_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmad_pkg::push_req_t           push,
    input  logic [mmad_pkg::Q_W-1:0]      scaled,
    output logic [mmad_pkg::SUM_W-1:0]    sum_next
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [mmad_pkg::Q_W-1:0]   ring_reg [CHANNELS][WINDOW];
    logic [mmad_pkg::SUM_W-1:0] sum_reg  [CHANNELS];
    logic [CH_IDX_W-1:0]        idx;
    logic [mmad_pkg::Q_W-1:0]   oldest;

    assign idx    = CH_IDX_W'(push.channel);
    // oldest sample sits at the far end of the line
    assign oldest = ring_reg[idx][WINDOW-1];

    // add the new sample, drop the oldest, wrap at 24 bits
    assign sum_next = sum_reg[idx] - mmad_pkg::SUM_W'(oldest)
                      + mmad_pkg::SUM_W'(scaled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
                for (int w = 0; w < WINDOW; w++)
                begin
                    ring_reg[c][w] <= '0;
                end
            end
        end
        else if (push.en)
        begin
            sum_reg[idx]     <= sum_next;
            ring_reg[idx][0] <= scaled;
            for (int w = 1; w < WINDOW; w++)
            begin
                ring_reg[idx][w] <= ring_reg[idx][w-1];
            end
        end
    end

endmodule

// ===== rtl/multichannel_moving_average_deadband.sv =====
// multichannel_moving_average_deadband: top level, apb registers, pipeline
// depends on mmad_pkg, mmad_if (mmad_in_if, mmad_out_if), mmad_window_sum
`timescale 1ns / 1ps

// One sample word (channel, Q4.12 pin voltage) enters per clock and one result
// word leaves per clock while the result side is not stalled. The five pipeline
// registers are: input, gain product, running sum, mean, result. Each per-channel
// store (window line and sum in the sum stage, held value in the result stage)
// is read and written in a single stage, so words of the same channel can follow
// each other without gaps. Each stage advances on its own, so the input side
// keeps taking words into empty stages while a result waits to be taken.
// Samples whose channel is not below CHANNELS are taken and dropped without a
// result. The window lines and sums start at zero and the sum is always
// divided by WINDOW, so the mean ramps up over a channel's first WINDOW
// samples. Registers: scale_factor (Q8.8 gain) at 0x0, update_threshold (Q8.12
// deadband) at 0x4; write them only while the block is idle. No clearing pass
// after reset.
module multichannel_moving_average_deadband #(
    parameter int WINDOW   = mmad_pkg::DEF_WINDOW,
    parameter int CHANNELS = mmad_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmad_pkg::ADDR_W-1:0]   paddr,
    input  logic [mmad_pkg::DATA_W-1:0]   pwdata,
    output logic [mmad_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // streams
    mmad_in_if.sink                       samples,
    mmad_out_if.source                    results
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W    = mmad_pkg::SUM_W;
    localparam int Q_W      = mmad_pkg::Q_W;
    localparam int CH_W     = mmad_pkg::CH_W;

    // divide by WINDOW as multiply by a rounded-up reciprocal, exact for 24-bit sums
    localparam int DIV_K  = SUM_W + $clog2(WINDOW);
    localparam int DPROD_W = SUM_W + DIV_K + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [DIV_K:0] RECIP = (DIV_K+1)'(RECIP_L);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [mmad_pkg::SCALE_W-1:0] scale_reg;
    logic [Q_W-1:0]               thresh_reg;
    logic                         cfg_we;
    mmad_pkg::reg_idx_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    // byte offset bits are ignored, registers are word aligned
    assign cfg_sel = mmad_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= mmad_pkg::SCALE_RESET;
            thresh_reg <= mmad_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                mmad_pkg::REG_SCALE:  scale_reg  <= pwdata[mmad_pkg::SCALE_W-1:0];
                mmad_pkg::REG_THRESH: thresh_reg <= pwdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            mmad_pkg::REG_SCALE:  prdata = mmad_pkg::DATA_W'(scale_reg);
            mmad_pkg::REG_THRESH: prdata = mmad_pkg::DATA_W'(thresh_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline registers
    // ---------------------------------------------------------------
    logic                          s1_valid_reg;
    logic [CH_W-1:0]               s1_channel_reg;
    logic [mmad_pkg::SAMPLE_W-1:0] s1_sample_reg;

    logic                          s2_valid_reg;
    logic [CH_W-1:0]               s2_channel_reg;
    logic [mmad_pkg::PROD_W-1:0]   s2_product_reg;

    logic                          s3_valid_reg;
    logic [CH_W-1:0]               s3_channel_reg;
    logic                          s3_sat_reg;
    logic [SUM_W-1:0]              s3_sum_reg;

    logic                          s4_valid_reg;
    logic [CH_W-1:0]               s4_channel_reg;
    logic                          s4_sat_reg;
    logic [Q_W-1:0]                s4_mean_reg;

    logic                          out_valid_reg;
    logic [CH_W-1:0]               out_channel_reg;
    logic [Q_W-1:0]                out_filtered_reg;
    logic [Q_W-1:0]                out_held_reg;
    logic                          out_updated_reg;
    logic                          out_sat_reg;

    logic [Q_W-1:0]                held_reg [CHANNELS];

    // ---------------------------------------------------------------
    // per-stage flow control: a stage takes a word when it is empty
    // or its word moves on in the same cycle
    // ---------------------------------------------------------------
    logic out_free, s4_free, s3_free, s2_free, s1_free;
    logic mv_out, mv4, mv3, mv2, in_take, ch_in_range;

    assign out_free = !out_valid_reg || results.ready;
    assign mv_out   = s4_valid_reg && out_free;
    assign s4_free  = !s4_valid_reg || mv_out;
    assign mv4      = s3_valid_reg && s4_free;
    assign s3_free  = !s3_valid_reg || mv4;
    assign mv3      = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || mv3;
    assign mv2      = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || mv2;

    assign samples.ready = s1_free;
    assign in_take       = samples.valid && s1_free;
    // out-of-range channels are taken but never enter the pipe
    assign ch_in_range   = 32'(samples.channel) < 32'(CHANNELS);

    // ---------------------------------------------------------------
    // stage datapath
    // ---------------------------------------------------------------
    // gain multiply, 16 x 16
    logic [mmad_pkg::PROD_W-1:0] s2_product_next;
    assign s2_product_next = mmad_pkg::PROD_W'(s1_sample_reg) * mmad_pkg::PROD_W'(scale_reg);

    // round half up to Q8.12 and clip
    localparam int ROUND_SHIFT_C = mmad_pkg::ROUND_SHIFT;
    logic [mmad_pkg::PROD_W:0]              rounded;
    logic [mmad_pkg::PROD_W-ROUND_SHIFT_C:0] q_wide;
    logic                                   sat_next;
    logic [Q_W-1:0]                         scaled;
    logic [SUM_W-1:0]                       s3_sum_next;
    mmad_pkg::push_req_t                    push;

    assign rounded  = {1'b0, s2_product_reg} + mmad_pkg::ROUND_HALF;
    assign q_wide   = rounded[mmad_pkg::PROD_W:ROUND_SHIFT_C];
    assign sat_next = |q_wide[mmad_pkg::PROD_W-ROUND_SHIFT_C:Q_W];
    assign scaled   = sat_next ? mmad_pkg::Q_MAX : q_wide[Q_W-1:0];

    assign push.en      = mv3;
    assign push.channel = s2_channel_reg;

    mmad_window_sum #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_window_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .scaled   (scaled),
        .sum_next (s3_sum_next)
    );

    // mean = sum / WINDOW by reciprocal multiply, clipped to Q8.12
    logic [DPROD_W-1:0] div_prod;
    logic [SUM_W-1:0]   quotient;
    logic [Q_W-1:0]     s4_mean_next;

    assign div_prod     = DPROD_W'(s3_sum_reg) * DPROD_W'(RECIP);
    assign quotient     = div_prod[DIV_K+SUM_W-1:DIV_K];
    assign s4_mean_next = (|quotient[SUM_W-1:Q_W]) ? mmad_pkg::Q_MAX : quotient[Q_W-1:0];

    // deadband check against the channel's held value
    logic [CH_IDX_W-1:0] s4_idx;
    logic [Q_W-1:0]      held_cur, gap;
    logic                upd_next;

    assign s4_idx   = CH_IDX_W'(s4_channel_reg);
    assign held_cur = held_reg[s4_idx];
    assign gap      = (s4_mean_reg > held_cur) ? (s4_mean_reg - held_cur)
                                               : (held_cur - s4_mean_reg);
    assign upd_next = gap > thresh_reg;

    // ---------------------------------------------------------------
    // valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_take && ch_in_range;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_channel_reg <= samples.channel;
            s1_sample_reg  <= samples.sample;
        end
        if (mv2)
        begin
            s2_channel_reg <= s1_channel_reg;
            s2_product_reg <= s2_product_next;
        end
        if (mv3)
        begin
            s3_channel_reg <= s2_channel_reg;
            s3_sat_reg     <= sat_next;
            s3_sum_reg     <= s3_sum_next;
        end
        if (mv4)
        begin
            s4_channel_reg <= s3_channel_reg;
            s4_sat_reg     <= s3_sat_reg;
            s4_mean_reg    <= s4_mean_next;
        end
        if (mv_out)
        begin
            out_channel_reg  <= s4_channel_reg;
            out_filtered_reg <= s4_mean_reg;
            out_held_reg     <= upd_next ? s4_mean_reg : held_cur;
            out_updated_reg  <= upd_next;
            out_sat_reg      <= s4_sat_reg;
        end
    end

    // held values start at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                held_reg[c] <= '0;
            end
        end
        else if (mv_out && upd_next)
        begin
            held_reg[s4_idx] <= s4_mean_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.filtered    = out_filtered_reg;
    assign results.held_value  = out_held_reg;
    assign results.updated     = out_updated_reg;
    assign results.saturated   = out_sat_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    logic [Q_W-1:0] out_gap;
    assign out_gap = (out_filtered_reg > out_held_reg) ? (out_filtered_reg - out_held_reg)
                                                       : (out_held_reg - out_filtered_reg);

    // a replaced held value is the mean of that same word
    a_update_takes_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_updated_reg |-> out_held_reg == out_filtered_reg)
        else $error("held value differs from mean on update");

    // a kept held value lies inside the deadband
    a_kept_inside_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_updated_reg |-> out_gap <= thresh_reg)
        else $error("held value kept although mean left the deadband");

    // a full pipe behind a stalled result must stop the input
    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
        && out_valid_reg && !results.ready |-> !samples.ready)
        else $error("input taken while the pipe is full and stalled");

    // a word moved to the result stage shows up as a valid result
    a_result_follows_move: assert property (@(posedge clk) disable iff (!rst_n)
        mv_out |=> out_valid_reg)
        else $error("result lost after leaving the mean stage");

endmodule

// ===== dv/multichannel_moving_average_deadband_test.sv =====
// multichannel_moving_average_deadband_test: self-checking bench for the multichannel
// moving average with deadband block, with its own predictor, random pacing and apb phases
// depends on mmad_pkg, mmad_if (mmad_in_if, mmad_out_if) and multichannel_moving_average_deadband
`timescale 1ns / 1ps

module multichannel_moving_average_deadband_test;

    localparam int N_WIN            = mmad_pkg::DEF_WINDOW;
    localparam int N_CHANNELS       = mmad_pkg::DEF_CHANNELS;
    localparam int N_PHASES         = 6;
    localparam int WORDS_PER_PHASE  = 115;
    // five pipeline stages plus some margin
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 120;

    typedef struct packed {
        logic [mmad_pkg::CH_W-1:0]     channel;
        logic [mmad_pkg::SAMPLE_W-1:0] sample;
    } sample_word_t;

    typedef struct packed {
        logic [mmad_pkg::CH_W-1:0] out_channel;
        logic [mmad_pkg::Q_W-1:0]  filtered;
        logic [mmad_pkg::Q_W-1:0]  held_value;
        logic                      updated;
        logic                      saturated;
    } average_word_t;

    // clock, reset and apb side, all known from time zero
    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [mmad_pkg::ADDR_W-1:0] paddr   = '0;
    logic [mmad_pkg::DATA_W-1:0] pwdata  = '0;
    logic [mmad_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    mmad_in_if  samples_if ();
    mmad_out_if results_if ();

    // stream inputs are driven from local registers so each has a single driver
    logic         in_valid_q  = 1'b0;
    sample_word_t in_word_q   = '0;
    logic         out_ready_q = 1'b0;

    assign samples_if.valid   = in_valid_q;
    assign samples_if.channel = in_word_q.channel;
    assign samples_if.sample  = in_word_q.sample;
    assign results_if.ready   = out_ready_q;

    multichannel_moving_average_deadband #(
        .WINDOW   (N_WIN),
        .CHANNELS (N_CHANNELS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if),
        .results (results_if)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: per-channel window, slot pointer, sum and held value
    // ------------------------------------------------------------------
    logic [mmad_pkg::SCALE_W-1:0] gain_cfg;
    logic [mmad_pkg::Q_W-1:0]     deadband_cfg;
    logic [mmad_pkg::Q_W-1:0]     win_mem  [N_CHANNELS][N_WIN];
    int unsigned                  win_slot [N_CHANNELS];
    logic [mmad_pkg::SUM_W-1:0]   win_sum  [N_CHANNELS];
    logic [mmad_pkg::Q_W-1:0]     held_mem [N_CHANNELS];

    sample_word_t  samples_to_send [$];
    average_word_t due_averages    [$];

    // bookkeeping
    logic          in_taken = 1'b0;
    int unsigned   mismatch_count = 0;
    int unsigned   words_taken = 0;
    int unsigned   results_seen = 0;
    int unsigned   n_updates = 0;
    int unsigned   n_clipped = 0;
    int unsigned   settings_run = 0;
    average_word_t got;
    average_word_t want;

    // input pacing
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned pace_roll;

    // output pacing
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    int unsigned hold_roll;
    logic        long_hold_done = 1'b0;

    // gain, round half up, clip to q8.12, then window update, mean and deadband
    function automatic average_word_t next_average(sample_word_t w);
        logic [mmad_pkg::PROD_W-1:0] product;
        logic [mmad_pkg::PROD_W:0]   rounded;
        logic [mmad_pkg::Q_W-1:0]    scaled;
        logic [mmad_pkg::SUM_W-1:0]  mean;
        logic [mmad_pkg::Q_W-1:0]    gap;
        int unsigned                 slot;
        average_word_t               r;
        product = mmad_pkg::PROD_W'(w.sample) * mmad_pkg::PROD_W'(gain_cfg);
        rounded = {1'b0, product} + 128;
        rounded = rounded >> 8;
        r.saturated = (rounded > mmad_pkg::Q_MAX);
        scaled = r.saturated ? mmad_pkg::Q_MAX : rounded[mmad_pkg::Q_W-1:0];
        // oldest entry leaves the sum as the new one enters
        slot = win_slot[w.channel];
        win_sum[w.channel] = win_sum[w.channel] - win_mem[w.channel][slot] + scaled;
        win_mem[w.channel][slot] = scaled;
        win_slot[w.channel] = (slot + 1 == N_WIN) ? 0 : slot + 1;
        // always divided by the full window, so the mean ramps up at start
        mean = win_sum[w.channel] / N_WIN;
        if (mean > mmad_pkg::Q_MAX)
            mean = mmad_pkg::Q_MAX;
        gap = (mean[mmad_pkg::Q_W-1:0] > held_mem[w.channel])
              ? mean[mmad_pkg::Q_W-1:0] - held_mem[w.channel]
              : held_mem[w.channel] - mean[mmad_pkg::Q_W-1:0];
        // strictly greater than the deadband
        r.updated = (gap > deadband_cfg);
        if (r.updated)
            held_mem[w.channel] = mean[mmad_pkg::Q_W-1:0];
        r.out_channel = w.channel;
        r.filtered    = mean[mmad_pkg::Q_W-1:0];
        r.held_value  = held_mem[w.channel];
        if (r.updated)
            n_updates++;
        if (r.saturated)
            n_clipped++;
        return r;
    endfunction

    function automatic sample_word_t word_of(int unsigned ch, int unsigned smp);
        sample_word_t w;
        w.channel = mmad_pkg::CH_W'(ch);
        w.sample  = mmad_pkg::SAMPLE_W'(smp);
        return w;
    endfunction

    // apb write: setup cycle, then access cycle until pready; mirror kept for prediction
    task automatic reg_write(input mmad_pkg::reg_idx_t idx,
                             input logic [mmad_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // only the register's own width is kept
        if (idx == mmad_pkg::REG_SCALE)
            gain_cfg = value[mmad_pkg::SCALE_W-1:0];
        else
            deadband_cfg = value[mmad_pkg::Q_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender pauses here until every expected word has come back, then the
    // pipeline is given time to settle before any register changes
    task automatic drain_results();
        do
            @(posedge clk);
        while (samples_to_send.size() != 0 || in_valid_q || due_averages.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // sample driver: changes at the falling edge, next word once the last was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid_q <= 1'b0;
        end
        else if (!in_valid_q || in_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid_q <= 1'b0;
            end
            else if (samples_to_send.size() != 0)
            begin
                in_word_q  <= samples_to_send.pop_front();
                in_valid_q <= 1'b1;
                // mostly back to back or short gaps, a few long ones, some bursts
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                else
                begin
                    pace_roll = $urandom_range(0, 99);
                    if (pace_roll < 4)
                        burst_left = $urandom_range(20, 60);
                    else if (pace_roll < 55)
                        gap_left = 0;
                    else if (pace_roll < 90)
                        gap_left = $urandom_range(1, 3);
                    else if (pace_roll < 98)
                        gap_left = $urandom_range(4, 10);
                    else
                        gap_left = $urandom_range(20, 50);
                end
            end
            else
            begin
                in_valid_q <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result ready: random stalls, calm stretches, and one long hold-off
    // that lets the pipeline fill and push back on the sample side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready_q <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready_q <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            out_ready_q <= 1'b0;
        end
        else if (calm_left != 0)
        begin
            calm_left--;
            out_ready_q <= 1'b1;
        end
        else
        begin
            hold_roll = $urandom_range(0, 99);
            if (hold_roll < 3)
            begin
                calm_left = $urandom_range(20, 80);
                out_ready_q <= 1'b1;
            end
            else if (hold_roll < 73)
            begin
                out_ready_q <= 1'b1;
            end
            else if (hold_roll < 95)
            begin
                stall_left = $urandom_range(0, 2);
                out_ready_q <= 1'b0;
            end
            else
            begin
                stall_left = $urandom_range(8, 30);
                out_ready_q <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: at the rising edge, predict each taken sample word and check
    // each taken result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid_q && samples_if.ready;
        if (in_taken)
        begin
            words_taken++;
            // a channel past the last one is taken without a result
            if (int'(in_word_q.channel) < N_CHANNELS)
                due_averages.push_back(next_average(in_word_q));
        end
        if (rst_n && results_if.valid && out_ready_q)
        begin
            got.out_channel = results_if.out_channel;
            got.filtered    = results_if.filtered;
            got.held_value  = results_if.held_value;
            got.updated     = results_if.updated;
            got.saturated   = results_if.saturated;
            results_seen++;
            if (due_averages.size() == 0)
            begin
                $error("result word with nothing pending: out_channel %0d filtered 0x%0h",
                       got.out_channel, got.filtered);
                mismatch_count++;
            end
            else
            begin
                want = due_averages.pop_front();
                if (got.out_channel !== want.out_channel)
                begin
                    $error("out_channel: expected %0d, got %0d",
                           want.out_channel, got.out_channel);
                    mismatch_count++;
                end
                if (got.filtered !== want.filtered)
                begin
                    $error("filtered: expected 0x%05h, got 0x%05h", want.filtered, got.filtered);
                    mismatch_count++;
                end
                if (got.held_value !== want.held_value)
                begin
                    $error("held_value: expected 0x%05h, got 0x%05h",
                           want.held_value, got.held_value);
                    mismatch_count++;
                end
                if (got.updated !== want.updated)
                begin
                    $error("updated: expected %0b, got %0b", want.updated, got.updated);
                    mismatch_count++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed words, then random phases under different settings
    // ------------------------------------------------------------------
    initial
    begin
        int                           lvl [N_CHANNELS];
        int                           roll;
        int unsigned                  ch;
        int unsigned                  smp;
        logic [mmad_pkg::SCALE_W-1:0] gain_pick [N_PHASES];
        logic [mmad_pkg::Q_W-1:0]     band_pick [N_PHASES];

        // predictor starts from the reset state
        gain_cfg     = mmad_pkg::SCALE_RESET;
        deadband_cfg = mmad_pkg::THRESH_RESET;
        for (int c = 0; c < N_CHANNELS; c++)
        begin
            win_slot[c] = 0;
            win_sum[c]  = '0;
            held_mem[c] = '0;
            lvl[c]      = $urandom_range(0, 65535);
            for (int s = 0; s < N_WIN; s++)
                win_mem[c][s] = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gain and deadband: zero, full scale (clips), clip boundary at
        // the default gain, mid values, and a start-up ramp on one channel
        samples_to_send.push_back(word_of(0, 16'h0000));
        samples_to_send.push_back(word_of(7, 16'hFFFF));
        samples_to_send.push_back(word_of(1, 47085));
        samples_to_send.push_back(word_of(2, 47086));
        samples_to_send.push_back(word_of(3, 16'h8000));
        samples_to_send.push_back(word_of(5, 16'h5555));
        samples_to_send.push_back(word_of(6, 16'hAAAA));
        repeat (4) samples_to_send.push_back(word_of(4, 16'h1000));
        drain_results();

        // unity gain: a mean exactly at the deadband does not update, one above does
        reg_write(mmad_pkg::REG_SCALE, 32'd256);
        reg_write(mmad_pkg::REG_THRESH, 32'd100);
        samples_to_send.push_back(word_of(0, 1000));
        samples_to_send.push_back(word_of(0, 10));
        samples_to_send.push_back(word_of(0, 0));
        drain_results();

        // tiny gain with no deadband: rounding halves up at the q8.12 step
        reg_write(mmad_pkg::REG_SCALE, 32'd1);
        reg_write(mmad_pkg::REG_THRESH, 32'd0);
        samples_to_send.push_back(word_of(2, 127));
        samples_to_send.push_back(word_of(2, 128));
        samples_to_send.push_back(word_of(2, 383));
        samples_to_send.push_back(word_of(2, 384));

        // settings per phase, extremes first; junk upper bits on every write
        gain_pick = '{16'hFFFF, 16'h0000, mmad_pkg::SCALE_RESET,
                      16'($urandom_range(200, 6000)), 16'($urandom), 16'd256};
        band_pick = '{20'd0, mmad_pkg::Q_MAX, mmad_pkg::THRESH_RESET,
                      20'($urandom_range(0, 2000)), 20'($urandom_range(0, 20000)), 20'd1};

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            reg_write(mmad_pkg::REG_SCALE, {16'($urandom), gain_pick[p]});
            reg_write(mmad_pkg::REG_THRESH, {12'($urandom), band_pick[p]});
            settings_run++;
            @(posedge clk);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                ch   = $urandom_range(0, N_CHANNELS - 1);
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    // extremes and walking ones
                    case ($urandom_range(0, 2))
                        0:       smp = 0;
                        1:       smp = 16'hFFFF;
                        default: smp = 1 << $urandom_range(0, 15);
                    endcase
                end
                else if (roll < 15)
                begin
                    // step change on a channel
                    lvl[ch] = $urandom_range(0, 65535);
                    smp = lvl[ch];
                end
                else if (roll < 60)
                begin
                    // slow drift around the channel's level, exercises the deadband
                    lvl[ch] = lvl[ch] + int'($urandom_range(0, 160)) - 80;
                    if (lvl[ch] < 0)
                        lvl[ch] = 0;
                    if (lvl[ch] > 65535)
                        lvl[ch] = 65535;
                    smp = lvl[ch];
                end
                else
                begin
                    smp = $urandom_range(0, 65535);
                end
                samples_to_send.push_back(word_of(ch, smp));
            end
        end

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d sample words over %0d register settings plus directed ones",
                 words_taken, settings_run);
        $display("%0d held-value updates, %0d clipped samples, one %0d-cycle result hold-off",
                 n_updates, n_clipped, LONG_HOLD_CYCLES);
        if (mismatch_count == 0 && due_averages.size() == 0)
            $display("multichannel_moving_average_deadband_test: done, clean");
        else
            $display("multichannel_moving_average_deadband_test: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("multichannel_moving_average_deadband_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmad_pkg.sv
rtl/mmad_if.sv
rtl/mmad_window_sum.sv
rtl/multichannel_moving_average_deadband.sv
dv/multichannel_moving_average_deadband_test.sv
